// ===== hdl/seqaln_pkg.sv =====
// Shared types and constants for the alignment text parser.
// Holds result kinds, parse phases, character codes and the result record.
`default_nettype none
package seqaln_pkg;

  localparam int POS_W = 20;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    KIND_HDR_BYTE = 3'd0,
    KIND_HDR_DONE = 3'd1,
    KIND_NAME     = 3'd2,
    KIND_TAB      = 3'd3,
    KIND_BASE     = 3'd4,
    KIND_LINE_END = 3'd5,
    KIND_DROP     = 3'd6,
    KIND_ERROR    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SAMPLES = 2'd1,
    PH_EOF     = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       byte_out;
    logic [POS_W-1:0] sample_index;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] sample_count;
    logic [POS_W-1:0] site_count;
  } res_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    sat_inc = (v == POS_MAX) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/seqaln_num_acc.sv =====
// Decimal digit accumulator with saturation for the header counts.
// Depends on seqaln_pkg for character codes.
`default_nettype none
module seqaln_num_acc #(
  parameter int W = 20
) (
  input  logic [W-1:0] num_i,
  input  logic         stop_i,
  input  logic [7:0]   byte_i,
  output logic [W-1:0] num_o,
  output logic         stop_o
);
  import seqaln_pkg::*;

  logic         is_digit;
  logic [3:0]   digit;
  logic [W+3:0] prod;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit    = 4'(byte_i - CH_ZERO);
  assign prod     = ({4'b0, num_i} << 3) + ({4'b0, num_i} << 1) + (W+4)'(digit);

  always_comb begin
    num_o  = num_i;
    stop_o = stop_i;
    if (!stop_i) begin
      if (is_digit) begin
        num_o = (|prod[W+3:W]) ? {W{1'b1}} : prod[W-1:0];
      end else begin
        stop_o = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/seqaln_parse.sv =====
// Parse state and per-byte classification for the alignment text parser.
// Depends on seqaln_pkg and seqaln_num_acc.
`default_nettype none
module seqaln_parse #(
  parameter int NAME_LIMIT  = 64,
  parameter int COUNT_WIDTH = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        byte_i,
  output seqaln_pkg::res_t  res
);
  import seqaln_pkg::*;

  localparam int BW = COUNT_WIDTH + 12;

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] first_r, first_nxt, second_r, second_nxt;
  logic                   first_stop_r, first_stop_nxt, second_stop_r, second_stop_nxt;
  logic                   space_seen_r, space_seen_nxt;
  logic [POS_W-1:0]       samp_r, samp_nxt, lpos_r, lpos_nxt, seq_start_r, seq_start_nxt;

  logic [COUNT_WIDTH-1:0] first_acc, second_acc;
  logic                   first_acc_stop, second_acc_stop;
  logic [POS_W-1:0]       first_w, second_w;
  logic                   line_end, in_seq, too_many, out_of_bound;
  logic [BW-1:0]          bound;

  seqaln_num_acc #(.W(COUNT_WIDTH)) u_first_acc (
    .num_i (first_r),
    .stop_i(first_stop_r),
    .byte_i(byte_i),
    .num_o (first_acc),
    .stop_o(first_acc_stop)
  );

  seqaln_num_acc #(.W(COUNT_WIDTH)) u_second_acc (
    .num_i (second_r),
    .stop_i(second_stop_r),
    .byte_i(byte_i),
    .num_o (second_acc),
    .stop_o(second_acc_stop)
  );

  generate
    if (COUNT_WIDTH >= POS_W) begin : g_trunc
      assign first_w  = first_r[POS_W-1:0];
      assign second_w = second_r[POS_W-1:0];
    end else begin : g_ext
      assign first_w  = {{(POS_W-COUNT_WIDTH){1'b0}}, first_r};
      assign second_w = {{(POS_W-COUNT_WIDTH){1'b0}}, second_r};
    end
  endgenerate

  assign line_end     = (byte_i == CH_NUL) || (byte_i == CH_LF);
  assign in_seq       = (seq_start_r != '0);
  assign bound        = BW'(second_r) + BW'(NAME_LIMIT);
  assign out_of_bound = (BW'(lpos_r) >= bound) || (lpos_r == POS_MAX);
  assign too_many     = (BW'(samp_r) >= BW'(first_r));

  always_comb begin
    phase_nxt       = phase_r;
    first_nxt       = first_r;
    first_stop_nxt  = first_stop_r;
    second_nxt      = second_r;
    second_stop_nxt = second_stop_r;
    space_seen_nxt  = space_seen_r;
    samp_nxt        = samp_r;
    lpos_nxt        = lpos_r;
    seq_start_nxt   = seq_start_r;

    res.kind         = KIND_DROP;
    res.byte_out     = byte_i;
    res.sample_index = samp_r;
    res.position     = '0;
    res.sample_count = first_w;
    res.site_count   = second_w;

    unique case (phase_r)
      PH_HEADER: begin
        res.sample_index = '0;
        res.position     = lpos_r;
        if (line_end) begin
          res.kind      = KIND_HDR_DONE;
          phase_nxt     = PH_SAMPLES;
          lpos_nxt      = '0;
          seq_start_nxt = '0;
        end else begin
          res.kind         = KIND_HDR_BYTE;
          res.sample_count = '0;
          res.site_count   = '0;
          if (byte_i == CH_SPACE) begin
            space_seen_nxt  = 1'b1;
            first_stop_nxt  = 1'b1;
            second_nxt      = '0;
            second_stop_nxt = 1'b0;
          end else begin
            first_nxt      = first_acc;
            first_stop_nxt = first_acc_stop;
            if (space_seen_r) begin
              second_nxt      = second_acc;
              second_stop_nxt = second_acc_stop;
            end
          end
          lpos_nxt = sat_inc(lpos_r);
        end
      end
      PH_SAMPLES: begin
        res.position = in_seq ? (lpos_r - seq_start_r) : lpos_r;
        if ((byte_i == CH_NUL) && (lpos_r == '0)) begin
          res.kind     = KIND_LINE_END;
          res.position = '0;
          phase_nxt    = PH_EOF;
        end else if (line_end) begin
          res.kind      = KIND_LINE_END;
          samp_nxt      = sat_inc(samp_r);
          lpos_nxt      = '0;
          seq_start_nxt = '0;
        end else begin
          if (out_of_bound) begin
            res.kind = KIND_DROP;
          end else if (in_seq) begin
            res.kind = too_many ? KIND_ERROR : KIND_BASE;
          end else if (byte_i == CH_TAB) begin
            res.kind = (too_many || (lpos_r >= POS_W'(NAME_LIMIT))) ? KIND_ERROR : KIND_TAB;
            seq_start_nxt = lpos_r + 1'b1;
          end else begin
            res.kind = (too_many || (lpos_r >= POS_W'(NAME_LIMIT - 1))) ?
                       KIND_ERROR : KIND_NAME;
          end
          lpos_nxt = sat_inc(lpos_r);
        end
      end
      default: begin
        res.kind     = KIND_DROP;
        res.position = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      first_r       <= '0;
      first_stop_r  <= 1'b0;
      second_r      <= '0;
      second_stop_r <= 1'b0;
      space_seen_r  <= 1'b0;
      samp_r        <= '0;
      lpos_r        <= '0;
      seq_start_r   <= '0;
    end else if (en) begin
      phase_r       <= phase_nxt;
      first_r       <= first_nxt;
      first_stop_r  <= first_stop_nxt;
      second_r      <= second_nxt;
      second_stop_r <= second_stop_nxt;
      space_seen_r  <= space_seen_nxt;
      samp_r        <= samp_nxt;
      lpos_r        <= lpos_nxt;
      seq_start_r   <= seq_start_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sequence_alignment_text_parser.sv =====
// Alignment text parser top level: input register, parse stage, result register.
// Depends on seqaln_pkg and seqaln_parse.
// A byte is held in the input register, its result in the result register; out_stall can hold either.
// Throughput: one byte per cycle while out_stall is low; the single parse stage between the registers sets it.
// Reset: synchronous rst_n clears both valid flags and all parse state.
`default_nettype none
module sequence_alignment_text_parser #(
  parameter int NAME_LIMIT  = 64,
  parameter int COUNT_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte_out,
  output logic [19:0] out_sample_index,
  output logic [19:0] out_position,
  output logic [19:0] out_sample_count,
  output logic [19:0] out_site_count
);
  import seqaln_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  res_t       res, res_r;
  logic       out_adv, s1_fire, in_fire;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_fire  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_valid_r && out_stall);

  seqaln_parse #(
    .NAME_LIMIT (NAME_LIMIT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_fire),
    .byte_i(s1_byte_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_text_byte;
    end
    if (s1_fire) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = res_r.kind;
  assign out_byte_out     = res_r.byte_out;
  assign out_sample_index = res_r.sample_index;
  assign out_position     = res_r.position;
  assign out_sample_count = res_r.sample_count;
  assign out_site_count   = res_r.site_count;

endmodule
`default_nettype wire

// ===== hdl/seqaln_checker.sv =====
// Port-level checks for the alignment text parser, bound to the top level.
// Depends on seqaln_pkg.
`default_nettype none
module seqaln_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_kind,
  input wire logic [7:0]  out_byte_out,
  input wire logic [19:0] out_sample_index,
  input wire logic [19:0] out_sample_count,
  input wire logic [19:0] out_site_count
);
  import seqaln_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte_out))
    else $error("stalled result changed");

  a_header_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_HDR_BYTE) |->
      (out_sample_index == '0) && (out_sample_count == '0) && (out_site_count == '0))
    else $error("header byte carries counts");

  a_line_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_LINE_END) || (out_kind == KIND_HDR_DONE)) |->
      (out_byte_out == CH_NUL) || (out_byte_out == CH_LF))
    else $error("line end without end byte");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && in_valid && !in_stall |=> out_valid)
    else $error("result lost while stalled");

endmodule

bind sequence_alignment_text_parser seqaln_checker u_seqaln_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_byte_out    (out_byte_out),
  .out_sample_index(out_sample_index),
  .out_sample_count(out_sample_count),
  .out_site_count  (out_site_count)
);
`default_nettype wire

// ===== dv/sequence_alignment_text_parser_tb.sv =====
// Testbench for sequence_alignment_text_parser: one header line, directed sample lines,
// then random well-formed and noisy lines, each result checked against a local model or the script.
// Depends on seqaln_pkg and the RTL top level only.
`timescale 1ns / 1ps

module sequence_alignment_text_parser_tb;
  import seqaln_pkg::*;

  localparam int NAME_LIMIT = 64;
  localparam int unsigned COUNT_MAX = 32'h000F_FFFF;
  localparam int RANDOM_BYTES = 1650;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    kind_t      kind;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte_out;
  logic [19:0] out_sample_index;
  logic [19:0] out_position;
  logic [19:0] out_sample_count;
  logic [19:0] out_site_count;

  sequence_alignment_text_parser uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte_out     (out_byte_out),
    .out_sample_index (out_sample_index),
    .out_position     (out_position),
    .out_sample_count (out_sample_count),
    .out_site_count   (out_site_count)
  );

  always #2 clk = ~clk;

  phase_t      parse_phase;
  logic [19:0] sample_total;
  logic [19:0] site_total;
  bit          sample_done;
  bit          space_seen;
  bit          site_done;
  logic [19:0] line_no;
  logic [19:0] line_pos;
  logic [19:0] seq_start;

  res_t classified_bytes[$];
  int   mismatches = 0;
  int   bytes_sent = 0;
  int   burst_left = 0;
  int   stall_pattern = 0;
  int   stall_left = 0;

  text_row_t script [23] = '{
    '{"4",      1'b1, KIND_HDR_BYTE},
    '{"0",      1'b1, KIND_HDR_BYTE},
    '{CH_SPACE, 1'b1, KIND_HDR_BYTE},
    '{"9",      1'b1, KIND_HDR_BYTE},
    '{"9",      1'b1, KIND_HDR_BYTE},
    '{"9",      1'b1, KIND_HDR_BYTE},
    '{"9",      1'b1, KIND_HDR_BYTE},
    '{"9",      1'b1, KIND_HDR_BYTE},
    '{"9",      1'b1, KIND_HDR_BYTE},
    '{"9",      1'b1, KIND_HDR_BYTE},
    '{CH_SPACE, 1'b1, KIND_HDR_BYTE},
    '{"3",      1'b1, KIND_HDR_BYTE},
    '{"x",      1'b1, KIND_HDR_BYTE},
    '{"1",      1'b1, KIND_HDR_BYTE},
    '{CH_LF,    1'b1, KIND_HDR_DONE},
    '{CH_LF,    1'b1, KIND_LINE_END},
    '{CH_TAB,   1'b1, KIND_TAB},
    '{8'hFF,    1'b1, KIND_BASE},
    '{CH_NUL,   1'b1, KIND_LINE_END},
    '{"n",      1'b1, KIND_NAME},
    '{CH_TAB,   1'b1, KIND_TAB},
    '{"A",      1'b0, KIND_BASE},
    '{CH_LF,    1'b1, KIND_LINE_END}
  };

  function automatic logic [19:0] bump(input logic [19:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [19:0] scan_digit(input logic [19:0] num, input logic [7:0] b);
    int unsigned d;
    int unsigned n;
    d = b - CH_ZERO;
    n = num;
    if (n > (COUNT_MAX - d) / 10) return 20'(COUNT_MAX);
    return 20'(n * 10 + d);
  endfunction

  task automatic reset_parser();
    parse_phase  = PH_HEADER;
    sample_total = '0;
    site_total   = '0;
    sample_done  = 1'b0;
    space_seen   = 1'b0;
    site_done    = 1'b0;
    line_no      = '0;
    line_pos     = '0;
    seq_start    = '0;
  endtask

  task automatic classify_byte(input logic [7:0] b, output res_t r);
    bit          line_end;
    bit          in_seq;
    bit          too_many;
    int unsigned bound;
    line_end       = (b == CH_NUL) || (b == CH_LF);
    r.byte_out     = b;
    r.sample_index = line_no;
    r.position     = '0;
    r.sample_count = sample_total;
    r.site_count   = site_total;
    case (parse_phase)
      PH_HEADER: begin
        r.sample_index = '0;
        r.position     = line_pos;
        if (line_end) begin
          r.kind      = KIND_HDR_DONE;
          parse_phase = PH_SAMPLES;
          line_pos    = '0;
          seq_start   = '0;
        end else begin
          r.kind         = KIND_HDR_BYTE;
          r.sample_count = '0;
          r.site_count   = '0;
          if (b == CH_SPACE) begin
            space_seen  = 1'b1;
            sample_done = 1'b1;
            site_total  = '0;
            site_done   = 1'b0;
          end else begin
            if (!sample_done) begin
              if (is_digit(b)) sample_total = scan_digit(sample_total, b);
              else sample_done = 1'b1;
            end
            if (space_seen && !site_done) begin
              if (is_digit(b)) site_total = scan_digit(site_total, b);
              else site_done = 1'b1;
            end
          end
          line_pos = bump(line_pos);
        end
      end
      PH_SAMPLES: begin
        in_seq     = (seq_start != '0);
        r.position = in_seq ? line_pos - seq_start : line_pos;
        if (b == CH_NUL && line_pos == '0) begin
          r.kind      = KIND_LINE_END;
          r.position  = '0;
          parse_phase = PH_EOF;
        end else if (line_end) begin
          r.kind    = KIND_LINE_END;
          line_no   = bump(line_no);
          line_pos  = '0;
          seq_start = '0;
        end else begin
          bound = site_total + NAME_LIMIT;
          if (line_pos >= bound || line_pos == POS_MAX) begin
            r.kind = KIND_DROP;
          end else begin
            too_many = (line_no >= sample_total);
            if (in_seq) begin
              r.kind = too_many ? KIND_ERROR : KIND_BASE;
            end else if (b == CH_TAB) begin
              r.kind    = (too_many || line_pos >= NAME_LIMIT) ? KIND_ERROR : KIND_TAB;
              seq_start = line_pos + 1'b1;
            end else begin
              r.kind = (too_many || line_pos >= NAME_LIMIT - 1) ? KIND_ERROR : KIND_NAME;
            end
          end
          line_pos = bump(line_pos);
        end
      end
      default: begin
        r.kind = KIND_DROP;
      end
    endcase
  endtask

  // keep a zero at line start from ending the file early
  function automatic logic [7:0] safe_byte(input logic [7:0] b);
    return (b == CH_NUL && line_pos == '0) ? CH_LF : b;
  endfunction

  function automatic logic [7:0] pick_base();
    string      alphabet;
    logic [7:0] b;
    alphabet = "ACGTN-";
    if ($urandom_range(0, 3) == 0) begin
      b = 8'($urandom_range(1, 255));
      if (b == CH_LF) b = "N";
    end else begin
      b = alphabet[$urandom_range(0, 5)];
    end
    return b;
  endfunction

  task automatic send_text(input logic [7:0] b, input bit typed, input kind_t kind);
    res_t r;
    int   gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     = 1'b1;
    in_text_byte = b;
    do @(posedge clk); while (in_stall);
    classify_byte(b, r);
    if (typed) r.kind = kind;
    classified_bytes.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_sample_line();
    int style;
    int name_len;
    int base_len;
    int noise_len;
    style    = $urandom_range(0, 9);
    name_len = $urandom_range(1, 10);
    base_len = $urandom_range(0, 12);
    case (style)
      0: begin
        noise_len = $urandom_range(0, 20);
        repeat (noise_len) send_text(safe_byte(8'($urandom_range(0, 255))), 1'b0, KIND_DROP);
      end
      2: name_len = $urandom_range(58, 72);
      3: base_len = $urandom_range(50, 80);
      default: ;
    endcase
    if (style != 0) begin
      repeat (name_len) send_text(8'($urandom_range(8'h21, 8'h7E)), 1'b0, KIND_NAME);
      if (style != 1) begin
        send_text(CH_TAB, 1'b0, KIND_TAB);
        repeat (base_len) send_text(pick_base(), 1'b0, KIND_BASE);
      end
    end
    send_text(($urandom_range(0, 7) == 0) ? safe_byte(CH_NUL) : CH_LF, 1'b0, KIND_LINE_END);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_pattern = $urandom_range(0, 2);
      stall_left    = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_pattern)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ((stall_left % 7) < 4);
    endcase
  end

  always @(posedge clk) begin : check_out
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (classified_bytes.size() == 0) begin
        $error("result transaction with nothing pending: byte %0h", out_byte_out);
        mismatches++;
      end else begin
        e = classified_bytes.pop_front();
        check_field("kind",         e.kind,         out_kind);
        check_field("byte_out",     e.byte_out,     out_byte_out);
        check_field("sample_index", e.sample_index, out_sample_index);
        check_field("position",     e.position,     out_position);
        check_field("sample_count", e.sample_count, out_sample_count);
        check_field("site_count",   e.site_count,   out_site_count);
      end
    end
  end

  initial begin
    reset_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (script[i]) send_text(script[i].ch, script[i].typed, script[i].kind);
    while (bytes_sent < RANDOM_BYTES + $size(script)) send_sample_line();
    // close the last line, end the file, then feed bytes past the end
    if (line_pos != '0) send_text(CH_LF, 1'b1, KIND_LINE_END);
    send_text(CH_NUL, 1'b1, KIND_LINE_END);
    send_text(CH_NUL, 1'b1, KIND_DROP);
    send_text(CH_LF, 1'b1, KIND_DROP);
    send_text(8'hFF, 1'b1, KIND_DROP);
    @(negedge clk);
    in_valid = 1'b0;
    while (classified_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
